// ===== hdl/assert_macros.svh =====
// assertion macros shared by the session table rtl
// every macro samples on clk and is held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/stg_pkg.sv =====
// shared types and constants for the session table replay guard
// no dependencies
`timescale 1ns / 1ps

package stg_pkg;

	localparam int unsigned ID_W   = 64;
	localparam int unsigned TIME_W = 63;
	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned LIFE_W = 40;
	localparam int unsigned ACT_W  = 5;
	localparam int unsigned STAT_W = 3;

	localparam longint unsigned SECS_PER_HOUR = 64'd3600;
	localparam longint unsigned TICKS_PER_SEC = 64'd10000000;
	// one hour of 100 ns ticks
	localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(SECS_PER_HOUR * TICKS_PER_SEC);

	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_DESTROY  = 2'd1,
		OP_VALIDATE = 2'd2,
		OP_REVOKE   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EXPIRED   = 3'd2,
		ST_REPLAY    = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		MM_SID,
		MM_PID_LIVE
	} match_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_CREATE,
		S_SCAN,
		S_VCHECK,
		S_REVOKE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [ID_W-1:0]   sid;
		logic [ID_W-1:0]   pid;
		logic [TIME_W-1:0] expiry;
		logic [SEQ_W-1:0]  last_seq;
		logic              live;
	} entry_t;

endpackage

// ===== hdl/stg_table.sv =====
// session entry storage: one write port, one registered read port
// depends on stg_pkg for the entry layout
`timescale 1ns / 1ps

module stg_table
	import stg_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data_s1,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/stg_match.sv =====
// entry compare unit shared by the destroy, validate and revoke table scans
// depends on stg_pkg for the entry layout and match modes
`timescale 1ns / 1ps

module stg_match
	import stg_pkg::*;
(
	input  match_mode_t     mode,
	input  logic [ID_W-1:0] key,
	input  entry_t          ent,
	output logic            hit
);

	always_comb begin
		case (mode)
			MM_SID:      hit = (ent.sid == key);
			MM_PID_LIVE: hit = (ent.pid == key) && ent.live;
			default:     hit = 1'b0;
		endcase
	end

endmodule

// ===== hdl/session_table_replay_guard_top.sv =====
// session table replay guard, top level; uses stg_pkg, stg_table, stg_match
// create goes IDLE, PREP, CREATE, DONE; destroy, validate and revoke go IDLE, PREP, SCAN,
//   walking entries one per cycle through the read port, a miss going on to DONE, a hit
//   to VCHECK, REVOKE or a shift moving every later entry down a slot (read then write back)
// throughput: one transaction at a time, next one taken the cycle after the result loads
// reset: entry count to zero, lifetime to one hour of ticks; table rams are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module session_table_replay_guard_top
	import stg_pkg::*;
#(
	parameter int unsigned MAX_SESSIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LIFE_W-1:0] lifetime_ticks,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [ID_W-1:0]   process_id,
	input  logic [ID_W-1:0]   session_id,
	input  logic [SEQ_W-1:0]  sequence_number,
	input  logic [TIME_W-1:0] current_time,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   new_session_id,
	output logic [TIME_W-1:0] expiry_time,
	output logic [ACT_W-1:0]  active_count
);

	localparam int unsigned AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
	localparam int unsigned CW = $clog2(MAX_SESSIONS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SESSIONS);

	fsm_t              state_q, state_d;
	logic [LIFE_W-1:0] life_q;
	logic [CW-1:0]     count_q;
	op_t               op_q;
	logic [ID_W-1:0]   pid_q;
	logic [ID_W-1:0]   sid_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] exp_q;
	logic [CW-1:0]     rd_idx_q;
	logic              cmp_v_s1;
	logic [AW-1:0]     cmp_idx_s1;
	logic [AW-1:0]     k_q;
	logic [CW-1:0]     src_q;
	entry_t            ent_q;
	status_t           res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [TIME_W-1:0] res_exp_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   new_id_q;
	logic [TIME_W-1:0] expiry_q;
	logic [ACT_W-1:0]  active_q;

	logic              tbl_rd_en;
	logic [AW-1:0]     tbl_rd_addr;
	entry_t            tbl_rd_data;
	logic              tbl_wr_en;
	logic [AW-1:0]     tbl_wr_addr;
	entry_t            tbl_wr_data;
	match_mode_t       match_mode;
	logic [ID_W-1:0]   match_key;
	logic              match_hit;
	logic              scan_issue;
	logic              scan_hit;
	logic              scan_miss;
	logic              table_full;
	logic              vc_expired;
	logic              vc_replay;
	logic              out_load;
	logic [CW-1:0]     src_prev;
	logic [ID_W:0]     exp_sum;
	logic [TIME_W-1:0] exp_sat;

	stg_table #(
		.DEPTH (MAX_SESSIONS),
		.AW    (AW)
	) u_table (
		.clk        (clk),
		.rd_en      (tbl_rd_en),
		.rd_addr    (tbl_rd_addr),
		.rd_data_s1 (tbl_rd_data),
		.wr_en      (tbl_wr_en),
		.wr_addr    (tbl_wr_addr),
		.wr_data    (tbl_wr_data)
	);

	stg_match u_match (
		.mode (match_mode),
		.key  (match_key),
		.ent  (tbl_rd_data),
		.hit  (match_hit)
	);

	assign match_mode = (op_q == OP_REVOKE) ? MM_PID_LIVE : MM_SID;
	assign match_key  = (op_q == OP_REVOKE) ? pid_q : sid_q;

	// expiry sum saturates at the top of the 63-bit time range
	assign exp_sum = {2'b00, now_q} + (ID_W + 1)'(life_q);
	assign exp_sat = (exp_sum[ID_W:TIME_W] != '0) ? '1 : exp_sum[TIME_W-1:0];

	assign table_full = (count_q == MAX_CNT);
	assign vc_expired = !ent_q.live || (now_q > ent_q.expiry);
	assign vc_replay  = (seq_q <= ent_q.last_seq);
	assign src_prev   = src_q - 1'b1;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d     = state_q;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = rd_idx_q[AW-1:0];
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = k_q;
		tbl_wr_data = ent_q;
		scan_issue  = 1'b0;
		scan_hit    = 1'b0;
		scan_miss   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (op_q == OP_CREATE) begin
					state_d = S_CREATE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_CREATE: begin
				if (!table_full) begin
					tbl_wr_en            = 1'b1;
					tbl_wr_addr          = count_q[AW-1:0];
					tbl_wr_data.sid      = {1'b0, now_q};
					tbl_wr_data.pid      = pid_q;
					tbl_wr_data.expiry   = exp_q;
					tbl_wr_data.last_seq = '0;
					tbl_wr_data.live     = 1'b1;
				end
				state_d = S_DONE;
			end
			S_SCAN: begin
				// reads go out one per cycle, compare sees the entry in the next cycle
				if (cmp_v_s1 && match_hit) begin
					scan_hit = 1'b1;
					case (op_q)
						OP_DESTROY:  state_d = S_SHIFT_RD;
						OP_VALIDATE: state_d = S_VCHECK;
						default:     state_d = S_REVOKE;
					endcase
				end else if (!cmp_v_s1 && (rd_idx_q == count_q)) begin
					scan_miss = 1'b1;
					state_d   = S_DONE;
				end else if (rd_idx_q != count_q) begin
					tbl_rd_en  = 1'b1;
					scan_issue = 1'b1;
				end
			end
			S_VCHECK: begin
				if (!vc_expired && !vc_replay) begin
					tbl_wr_en            = 1'b1;
					tbl_wr_data.last_seq = seq_q;
					tbl_wr_data.expiry   = exp_q;
				end
				state_d = S_DONE;
			end
			S_REVOKE: begin
				tbl_wr_en        = 1'b1;
				tbl_wr_data.live = 1'b0;
				state_d          = S_DONE;
			end
			S_SHIFT_RD: begin
				if (src_q != count_q) begin
					tbl_rd_en   = 1'b1;
					tbl_rd_addr = src_q[AW-1:0];
					state_d     = S_SHIFT_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_WR: begin
				tbl_wr_en   = 1'b1;
				tbl_wr_addr = src_prev[AW-1:0];
				tbl_wr_data = tbl_rd_data;
				state_d     = S_SHIFT_RD;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			life_q      <= LIFETIME_RESET;
			count_q     <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				life_q <= lifetime_ticks;
			end
			if ((state_q == S_CREATE) && !table_full) begin
				count_q <= count_q + 1'b1;
			end else if ((state_q == S_SHIFT_RD) && (src_q == count_q)) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == S_SCAN) begin
				cmp_v_s1 <= scan_issue;
			end else begin
				cmp_v_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			op_q  <= op_t'(operation);
			pid_q <= process_id;
			sid_q <= session_id;
			seq_q <= sequence_number;
			now_q <= current_time;
		end
		if (state_q == S_PREP) begin
			exp_q        <= exp_sat;
			rd_idx_q     <= '0;
			res_status_q <= ST_OK;
			res_id_q     <= '0;
			res_exp_q    <= '0;
		end
		if (scan_issue) begin
			rd_idx_q   <= rd_idx_q + 1'b1;
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (scan_hit) begin
			k_q   <= cmp_idx_s1;
			ent_q <= tbl_rd_data;
			src_q <= CW'(cmp_idx_s1) + 1'b1;
		end
		if (scan_miss) begin
			res_status_q <= ST_NOT_FOUND;
		end
		if (state_q == S_SHIFT_WR) begin
			src_q <= src_q + 1'b1;
		end
		if (state_q == S_CREATE) begin
			if (table_full) begin
				res_status_q <= ST_FULL;
			end else begin
				res_id_q  <= {1'b0, now_q};
				res_exp_q <= exp_q;
			end
		end
		if (state_q == S_VCHECK) begin
			if (vc_expired) begin
				res_status_q <= ST_EXPIRED;
			end else if (vc_replay) begin
				res_status_q <= ST_REPLAY;
			end else begin
				res_exp_q <= exp_q;
			end
		end
		if (out_load) begin
			status_q <= res_status_q;
			new_id_q <= res_id_q;
			expiry_q <= res_exp_q;
			active_q <= ACT_W'(count_q);
		end
	end

	assign cfg_ready      = 1'b1;
	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign new_session_id = new_id_q;
	assign expiry_time    = expiry_q;
	assign active_count   = active_q;

	`ASSERT_CLK(a_count_max, count_q <= MAX_CNT, "entry count above table depth")
	`ASSERT_IMPL(a_count_step, count_q != $past(count_q), (count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q)), "entry count moved by more than one")
	`ASSERT_IMPL(a_cmp_in_range, cmp_v_s1, CW'(cmp_idx_s1) < count_q, "compare stage beyond filled entries")
	`ASSERT_NEXT(a_done_holds, (state_q == S_DONE) && out_valid_q && out_stall, state_q == S_DONE, "result dropped while output stalled")

endmodule

// ===== tb/stg_checker.sv =====
// session table checker: keeps its own copy of the session table and lifetime,
// predicts one result per accepted request and compares it with the block's result
`timescale 1ns / 1ps

module stg_checker
	import stg_pkg::*;
#(
	parameter int unsigned MAX_SESSIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [LIFE_W-1:0] lifetime_ticks,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [ID_W-1:0]   process_id,
	input  logic [ID_W-1:0]   session_id,
	input  logic [SEQ_W-1:0]  sequence_number,
	input  logic [TIME_W-1:0] current_time,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [STAT_W-1:0] status,
	input  logic [ID_W-1:0]   new_session_id,
	input  logic [TIME_W-1:0] expiry_time,
	input  logic [ACT_W-1:0]  active_count,
	output int                errors,
	output int                awaiting
);

	typedef struct {
		status_t           st;
		logic [ID_W-1:0]   new_id;
		logic [TIME_W-1:0] expiry;
		logic [ACT_W-1:0]  count;
	} outcome_t;

	entry_t            sessions [MAX_SESSIONS];
	int unsigned       session_cnt;
	logic [LIFE_W-1:0] lifetime;
	outcome_t          outcome_q [$];
	int                err_cnt;

	// now plus lifetime, clamped to the largest 63-bit time
	function automatic logic [TIME_W-1:0] expiry_at(input logic [TIME_W-1:0] now);
		logic [ID_W-1:0] sum;
		sum = ID_W'(now) + ID_W'(lifetime);
		return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	endfunction

	// oldest slot with this id, live or not
	function automatic int find_session(input logic [ID_W-1:0] id);
		int i;
		for (i = 0; i < int'(session_cnt); i++)
			if (sessions[i].sid == id)
				return i;
		return -1;
	endfunction

	// oldest live slot of this process
	function automatic int find_live_process(input logic [ID_W-1:0] pid);
		int i;
		for (i = 0; i < int'(session_cnt); i++)
			if (sessions[i].pid == pid && sessions[i].live)
				return i;
		return -1;
	endfunction

	function automatic outcome_t apply_request(input op_t op, input logic [ID_W-1:0] pid,
		input logic [ID_W-1:0] sid, input logic [SEQ_W-1:0] seq,
		input logic [TIME_W-1:0] now);
		outcome_t r;
		int k;
		int i;
		r.st = ST_OK;
		r.new_id = '0;
		r.expiry = '0;
		case (op)
			OP_CREATE: begin
				if (session_cnt >= MAX_SESSIONS) begin
					r.st = ST_FULL;
				end else begin
					sessions[session_cnt].sid = ID_W'(now);
					sessions[session_cnt].pid = pid;
					sessions[session_cnt].expiry = expiry_at(now);
					sessions[session_cnt].last_seq = '0;
					sessions[session_cnt].live = 1'b1;
					r.new_id = ID_W'(now);
					r.expiry = sessions[session_cnt].expiry;
					session_cnt++;
				end
			end
			OP_DESTROY: begin
				k = find_session(sid);
				if (k < 0) begin
					r.st = ST_NOT_FOUND;
				end else begin
					// close the gap so insertion order is kept
					for (i = k; i + 1 < int'(session_cnt); i++)
						sessions[i] = sessions[i + 1];
					session_cnt--;
				end
			end
			OP_VALIDATE: begin
				k = find_session(sid);
				if (k < 0) begin
					r.st = ST_NOT_FOUND;
				end else if (!sessions[k].live || now > sessions[k].expiry) begin
					r.st = ST_EXPIRED;
				end else if (seq <= sessions[k].last_seq) begin
					r.st = ST_REPLAY;
				end else begin
					sessions[k].last_seq = seq;
					sessions[k].expiry = expiry_at(now);
					r.expiry = sessions[k].expiry;
				end
			end
			default: begin
				k = find_live_process(pid);
				if (k < 0)
					r.st = ST_NOT_FOUND;
				else
					sessions[k].live = 1'b0;
			end
		endcase
		r.count = ACT_W'(session_cnt);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [ID_W-1:0] want,
		input logic [ID_W-1:0] got);
		if (want !== got) begin
			$display("%0t stg_checker: %s expected %0h got %0h", $time, name, want, got);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			session_cnt = 0;
			lifetime = LIFETIME_RESET;
			outcome_q.delete();
			err_cnt = 0;
			errors <= 0;
			awaiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$display("%0t stg_checker: result with nothing expected, status %0d",
						$time, status);
					err_cnt++;
				end else begin
					want = outcome_q.pop_front();
					check_field("status", ID_W'(want.st), ID_W'(status));
					check_field("new_session_id", want.new_id, new_session_id);
					check_field("expiry_time", ID_W'(want.expiry), ID_W'(expiry_time));
					check_field("active_count", ID_W'(want.count), ID_W'(active_count));
				end
			end
			if (cfg_valid && cfg_ready)
				lifetime = lifetime_ticks;
			if (in_valid && !in_stall)
				outcome_q.push_back(apply_request(op_t'(operation), process_id, session_id,
					sequence_number, current_time));
			errors <= err_cnt;
			awaiting <= outcome_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the session table replay guard: drives requests, lifetime writes
// and result back-pressure; instantiates the block and stg_checker; uses stg_pkg
`timescale 1ns / 1ps

module tb_top;
	import stg_pkg::*;

	localparam int unsigned       N_SLOTS      = 16;
	localparam logic [TIME_W-1:0] TIME_MAX     = '1;
	localparam logic [LIFE_W-1:0] LIFETIME_MAX = 40'd864000000000;
	localparam logic [TIME_W-1:0] LIFE_DEF     = TIME_W'(LIFETIME_RESET);

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LIFE_W-1:0] lifetime_ticks;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        operation;
	logic [ID_W-1:0]   process_id;
	logic [ID_W-1:0]   session_id;
	logic [SEQ_W-1:0]  sequence_number;
	logic [TIME_W-1:0] current_time;
	logic              out_valid;
	logic              out_stall;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   new_session_id;
	logic [TIME_W-1:0] expiry_time;
	logic [ACT_W-1:0]  active_count;

	int chk_errors;
	int chk_pending;

	// stimulus shaping state
	int                in_idle_pct;
	int                out_stall_pct;
	int                hold_asked;
	logic [TIME_W-1:0] now_t;
	logic [LIFE_W-1:0] life_cur;
	logic [SEQ_W-1:0]  seq_ctr;
	logic [ID_W-1:0]   table_ids [$];

	session_table_replay_guard_top #(
		.MAX_SESSIONS(N_SLOTS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.lifetime_ticks (lifetime_ticks),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.process_id     (process_id),
		.session_id     (session_id),
		.sequence_number(sequence_number),
		.current_time   (current_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.new_session_id (new_session_id),
		.expiry_time    (expiry_time),
		.active_count   (active_count)
	);

	stg_checker #(
		.MAX_SESSIONS(N_SLOTS)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.lifetime_ticks (lifetime_ticks),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.process_id     (process_id),
		.session_id     (session_id),
		.sequence_number(sequence_number),
		.current_time   (current_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.new_session_id (new_session_id),
		.expiry_time    (expiry_time),
		.active_count   (active_count),
		.errors         (chk_errors),
		.awaiting       (chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// result side: random stall, or a long hold-off when one is asked for
	initial begin : sink
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = 400;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
			end
		end
	end

	function automatic logic [ID_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// present one request and hold it until the block takes it
	task automatic issue(input op_t op, input logic [ID_W-1:0] pid,
		input logic [ID_W-1:0] sid, input logic [SEQ_W-1:0] seq,
		input logic [TIME_W-1:0] now);
		int k;
		int hit;
		hit = -1;
		@(negedge clk);
		while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		process_id <= pid;
		session_id <= sid;
		sequence_number <= seq;
		current_time <= now;
		do @(posedge clk); while (in_stall);
		// track which ids sit in the table so destroy and validate mostly hit
		if (op == OP_CREATE && table_ids.size() < N_SLOTS) begin
			table_ids.push_back(ID_W'(now));
		end else if (op == OP_DESTROY) begin
			for (k = 0; k < table_ids.size(); k++)
				if (hit < 0 && table_ids[k] == sid)
					hit = k;
			if (hit >= 0)
				table_ids.delete(hit);
		end
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (chk_pending == 0);
	endtask

	task automatic write_lifetime(input logic [LIFE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		lifetime_ticks <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		life_cur = value;
	endtask

	task automatic advance_time();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			now_t = now_t;
		else if (r < 75)
			now_t = now_t + TIME_W'($urandom_range(1, 8));
		else if (r < 96)
			now_t = now_t + TIME_W'(rand64() % (ID_W'(life_cur) + 1));
		else
			now_t = TIME_W'(rand64());
	endtask

	task automatic session_traffic(input int n);
		int i;
		int r;
		op_t op;
		logic [ID_W-1:0] pid;
		logic [ID_W-1:0] sid;
		logic [SEQ_W-1:0] seq;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			op = r < 30 ? OP_CREATE : r < 50 ? OP_DESTROY : r < 85 ? OP_VALIDATE : OP_REVOKE;
			advance_time();
			r = $urandom_range(9);
			pid = r < 1 ? '1 : r < 9 ? ID_W'($urandom_range(3)) : rand64();
			if (table_ids.size() > 0 && $urandom_range(99) < 85)
				sid = table_ids[$urandom_range(table_ids.size() - 1)];
			else
				sid = rand64();
			r = $urandom_range(99);
			if (r < 80) begin
				seq_ctr = seq_ctr + SEQ_W'($urandom_range(1, 4));
				seq = seq_ctr;
			end else if (r < 88) begin
				seq = $urandom;
			end else if (r < 94) begin
				seq = '0;
			end else begin
				seq = seq_ctr;
			end
			issue(op, pid, sid, seq, now_t);
		end
	endtask

	initial begin : stimulus
		int i;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		lifetime_ticks = '0;
		in_valid = 1'b0;
		operation = OP_CREATE;
		process_id = '0;
		session_id = '0;
		sequence_number = '0;
		current_time = '0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_asked = 0;
		now_t = '0;
		seq_ctr = '0;
		life_cur = LIFETIME_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the table, three entries share id zero
		for (i = 0; i < N_SLOTS; i++)
			issue(OP_CREATE, i == 0 ? '0 : i % 2 ? '1 : ID_W'(i), '0, '0,
				i < 3 ? '0 : TIME_W'(i * 10));
		issue(OP_CREATE, 7, '0, '0, 200);
		// fresh entry holds sequence zero
		issue(OP_VALIDATE, '0, '0, '0, 200);
		issue(OP_VALIDATE, '0, '0, '1, 200);
		issue(OP_REVOKE, '0, '1, '0, 200);
		// revoked entry is still the oldest match
		issue(OP_VALIDATE, '1, '0, 5, 200);
		issue(OP_REVOKE, '0, '0, '0, 200);
		issue(OP_DESTROY, '0, '0, '0, 200);
		issue(OP_VALIDATE, '0, '0, 1, 200);
		// exactly at expiry is still valid, one tick later is not
		issue(OP_VALIDATE, '0, '0, 2, 200 + LIFE_DEF);
		issue(OP_VALIDATE, '0, '0, 3, 200 + 2 * LIFE_DEF + 1);
		issue(OP_VALIDATE, '0, '1, 1, 200 + 2 * LIFE_DEF + 1);
		issue(OP_DESTROY, '0, '1, '0, 200 + 2 * LIFE_DEF + 1);
		// expiry clamps at the top of the time range
		issue(OP_CREATE, 3, '0, '0, TIME_MAX - 5);
		issue(OP_VALIDATE, '0, ID_W'(TIME_MAX - 5), 1, TIME_MAX);

		now_t = 1000;
		settle();
		write_lifetime('0);
		session_traffic(100);
		// long hold-off on results while requests keep coming
		hold_asked++;
		session_traffic(400);

		settle();
		write_lifetime(LIFETIME_MAX);
		in_idle_pct = 71;
		session_traffic(500);

		settle();
		write_lifetime(LIFE_W'($urandom_range(1, 64)));
		in_idle_pct = 0;
		out_stall_pct = 71;
		session_traffic(500);

		settle();
		write_lifetime(40'h7F_FFFF_FFFF);
		in_idle_pct = 37;
		out_stall_pct = 37;
		session_traffic(250);

		settle();
		write_lifetime(LIFE_W'(rand64() % (ID_W'(LIFETIME_MAX) + 1)));
		session_traffic(250);

		settle();
		out_stall_pct = 0;
		repeat (60) @(posedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
